@@ sv/bldc6_pkg.sv @@
// shared constants, types and commutation tables for the six-step commutator
package bldc6_pkg;

  localparam int CMP_W   = 16;
  localparam int Q8_W    = 24;
  localparam int STEP_W  = 17;
  localparam int PHASE_W = 3;
  localparam int SLICE_W = 2;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DUTY_DEC_W = Q8_W + STEP_W;
  localparam int PER_DEC_W  = CMP_W + STEP_W;

  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STARTUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd2;

  localparam logic [CMP_W-1:0]   REF_THRESHOLD     = 16'd125;
  localparam logic [CMP_W-1:0]   PERIOD_AFTER_RAMP = 16'hFFFF;
  localparam logic [PHASE_W-1:0] LAST_PHASE        = 3'd5;

  localparam logic [SLICE_W-1:0] SLICE_U = 2'd0;
  localparam logic [SLICE_W-1:0] SLICE_V = 2'd1;
  localparam logic [SLICE_W-1:0] SLICE_W_PH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_CMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_PER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PER_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TICKS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TICKS  = 3'd7;

  // configuration reset values
  localparam logic [CMP_W-1:0] RST_PWM_PERIOD = 16'd1279;
  localparam logic [CMP_W-1:0] RST_LOCK_CMP   = 16'd511;
  localparam logic [Q8_W-1:0]  RST_DUTY_START = 24'd130970;
  localparam logic [Q8_W-1:0]  RST_DUTY_STEP  = 24'd910;
  localparam logic [CMP_W-1:0] RST_START_PER  = 16'd20618;
  localparam logic [CMP_W-1:0] RST_PER_STEP   = 16'd243;
  localparam logic [CMP_W-1:0] RST_LOCK_TICKS = 16'd19;
  localparam logic [CMP_W-1:0] RST_RAMP_TICKS = 16'd72;

  typedef struct packed {
    logic [CMP_W-1:0]   u_hi;
    logic [CMP_W-1:0]   u_lo;
    logic [CMP_W-1:0]   v_hi;
    logic [CMP_W-1:0]   v_lo;
    logic [CMP_W-1:0]   w_hi;
    logic [CMP_W-1:0]   w_lo;
    logic [CMP_W-1:0]   trig;
    logic [SLICE_W-1:0] measure;
  } drive_t;

  // slice that switches its high side in each step
  function automatic logic [SLICE_W-1:0] hi_slice(input logic [PHASE_W-1:0] ph);
    logic [SLICE_W-1:0] s;
    case (ph)
      3'd0, 3'd1: s = SLICE_U;
      3'd2, 3'd3: s = SLICE_V;
      default:    s = SLICE_W_PH;
    endcase
    return s;
  endfunction

  // slice whose low side is held on
  function automatic logic [SLICE_W-1:0] low_slice(input logic [PHASE_W-1:0] ph);
    logic [SLICE_W-1:0] s;
    case (ph)
      3'd0:       s = SLICE_V;
      3'd1, 3'd2: s = SLICE_W_PH;
      3'd3, 3'd4: s = SLICE_U;
      default:    s = SLICE_V;
    endcase
    return s;
  endfunction

  // floating slice to sample
  function automatic logic [SLICE_W-1:0] sense_slice(input logic [PHASE_W-1:0] ph);
    logic [SLICE_W-1:0] s;
    case (ph)
      3'd0, 3'd3: s = SLICE_W_PH;
      3'd1, 3'd4: s = SLICE_V;
      default:    s = SLICE_U;
    endcase
    return s;
  endfunction

endpackage

@@ sv/bldc6_if.sv @@
// handshake interfaces for the input and result channels

interface bldc6_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] reference;

  modport source (output valid, output kind, output reference, input ready);
  modport sink   (input valid, input kind, input reference, output ready);
endinterface

interface bldc6_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [1:0]  measure_phase;
  logic [15:0] u_high_compare;
  logic [15:0] u_low_compare;
  logic [15:0] v_high_compare;
  logic [15:0] v_low_compare;
  logic [15:0] w_high_compare;
  logic [15:0] w_low_compare;
  logic [15:0] sample_trigger;
  logic [15:0] commutation_period;
  logic [1:0]  motor_mode;
  logic        accepted;

  modport source (
    output valid, output phase, output measure_phase,
    output u_high_compare, output u_low_compare,
    output v_high_compare, output v_low_compare,
    output w_high_compare, output w_low_compare,
    output sample_trigger, output commutation_period,
    output motor_mode, output accepted,
    input ready
  );
  modport sink (
    input valid, input phase, input measure_phase,
    input u_high_compare, input u_low_compare,
    input v_high_compare, input v_low_compare,
    input w_high_compare, input w_low_compare,
    input sample_trigger, input commutation_period,
    input motor_mode, input accepted,
    output ready
  );
endinterface

@@ sv/bldc6_drive.sv @@
// half-bridge compare pattern and sense phase for one commutation step
module bldc6_drive
  import bldc6_pkg::*;
(
  input  logic [PHASE_W-1:0] phase,
  input  logic [CMP_W-1:0]   duty,
  input  logic [CMP_W-1:0]   off_level,
  input  logic [CMP_W-1:0]   trig,
  output drive_t             drive
);

  logic [SLICE_W-1:0] hi_s;
  logic [SLICE_W-1:0] lo_s;

  assign hi_s = hi_slice(phase);
  assign lo_s = low_slice(phase);

  always_comb begin
    drive.u_hi    = (hi_s == SLICE_U)    ? duty : '0;
    drive.v_hi    = (hi_s == SLICE_V)    ? duty : '0;
    drive.w_hi    = (hi_s == SLICE_W_PH) ? duty : '0;
    drive.u_lo    = (lo_s == SLICE_U)    ? '0 : off_level;
    drive.v_lo    = (lo_s == SLICE_V)    ? '0 : off_level;
    drive.w_lo    = (lo_s == SLICE_W_PH) ? '0 : off_level;
    drive.trig    = trig;
    drive.measure = sense_slice(phase);
  end

endmodule

@@ sv/bldc_six_step_openloop_start.sv @@
// six-step bldc commutator with rotor lock and open-loop ramp start-up
// an accepted input word passes the input register, then the result register, to its result word
// throughput: one word per cycle while out_ch.ready is high; the state update is a single registered pass
// the ramp arithmetic (two narrow multiplies) sits between the input and result registers
// reset: synchronous active-low rst_n; motor stopped, phase 0, compares 0, sense on W,
// configuration registers back to their default values
module bldc_six_step_openloop_start
  import bldc6_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bldc6_in_if.sink              in_ch,
  bldc6_out_if.source           out_ch
);

  // configuration registers
  logic [CMP_W-1:0] pwm_period_r;
  logic [CMP_W-1:0] lock_cmp_r;
  logic [Q8_W-1:0]  duty_start_r;
  logic [Q8_W-1:0]  duty_step_r;
  logic [CMP_W-1:0] start_per_r;
  logic [CMP_W-1:0] per_step_r;
  logic [CMP_W-1:0] lock_ticks_r;
  logic [CMP_W-1:0] ramp_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= RST_PWM_PERIOD;
      lock_cmp_r   <= RST_LOCK_CMP;
      duty_start_r <= RST_DUTY_START;
      duty_step_r  <= RST_DUTY_STEP;
      start_per_r  <= RST_START_PER;
      per_step_r   <= RST_PER_STEP;
      lock_ticks_r <= RST_LOCK_TICKS;
      ramp_ticks_r <= RST_RAMP_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD: pwm_period_r <= cfg_wdata[CMP_W-1:0];
        REG_LOCK_CMP:   lock_cmp_r   <= cfg_wdata[CMP_W-1:0];
        REG_DUTY_START: duty_start_r <= cfg_wdata[Q8_W-1:0];
        REG_DUTY_STEP:  duty_step_r  <= cfg_wdata[Q8_W-1:0];
        REG_START_PER:  start_per_r  <= cfg_wdata[CMP_W-1:0];
        REG_PER_STEP:   per_step_r   <= cfg_wdata[CMP_W-1:0];
        REG_LOCK_TICKS: lock_ticks_r <= cfg_wdata[CMP_W-1:0];
        REG_RAMP_TICKS: ramp_ticks_r <= cfg_wdata[CMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: input register feeds the update pass, result register holds the output word
  logic             s1_vld_r;
  logic             s1_kind_r;
  logic [CMP_W-1:0] s1_ref_r;
  logic             out_vld_r;
  logic             out_free;
  logic             s2_fire;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign s2_fire     = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_kind_r <= in_ch.kind;
      s1_ref_r  <= in_ch.reference;
    end
  end

  // motor state
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic               ramp_done_r, ramp_done_nxt;
  logic [STEP_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CMP_W-1:0]   duty_r, duty_nxt;
  logic [CMP_W-1:0]   period_r, period_nxt;
  drive_t             drive_r, drive_nxt;
  logic               acc_nxt;

  // off level wraps at 16 bits
  logic [CMP_W-1:0] off_level;
  assign off_level = pwm_period_r + 16'd1;

  // ramp arithmetic: k counts ramp ticks from one
  logic [STEP_W-1:0]     sc_inc;
  logic                  in_lock;
  logic [STEP_W-1:0]     ramp_k;
  logic [STEP_W-1:0]     ramp_km1;
  logic [DUTY_DEC_W-1:0] duty_dec;
  logic [PER_DEC_W-1:0]  per_dec;
  logic [Q8_W-1:0]       duty_q8;
  logic [CMP_W-1:0]      ramp_duty;
  logic [CMP_W-1:0]      ramp_per;
  logic                  ramp_end;
  logic [PHASE_W-1:0]    phase_adv;

  assign sc_inc    = step_cnt_r + 17'd1;
  assign in_lock   = sc_inc <= {1'b0, lock_ticks_r};
  assign ramp_k    = sc_inc - {1'b0, lock_ticks_r};
  assign ramp_km1  = ramp_k - 17'd1;
  assign duty_dec  = DUTY_DEC_W'(duty_step_r) * DUTY_DEC_W'(ramp_km1);
  assign per_dec   = PER_DEC_W'(per_step_r) * PER_DEC_W'(ramp_k);
  // duty and period saturate at zero
  assign duty_q8   = (duty_dec >= DUTY_DEC_W'(duty_start_r)) ? '0
                     : duty_start_r - duty_dec[Q8_W-1:0];
  assign ramp_duty = duty_q8[Q8_W-1:8];
  assign ramp_per  = (per_dec >= PER_DEC_W'(start_per_r)) ? '0
                     : start_per_r - per_dec[CMP_W-1:0];
  assign ramp_end  = ramp_k >= {1'b0, ramp_ticks_r};
  assign phase_adv = (phase_r == LAST_PHASE) ? '0 : phase_r + 3'd1;

  // next-state pass for one word
  logic load_drive;
  logic lock_path;
  logic ref_hi;

  assign ref_hi = s1_ref_r > REF_THRESHOLD;

  always_comb begin
    mode_nxt      = mode_r;
    ramp_done_nxt = ramp_done_r;
    step_cnt_nxt  = step_cnt_r;
    phase_nxt     = phase_r;
    duty_nxt      = duty_r;
    period_nxt    = period_r;
    acc_nxt       = 1'b0;
    load_drive    = 1'b0;
    lock_path     = 1'b0;
    if (s2_fire) begin
      if (!s1_kind_r) begin
        // commutation tick
        if (mode_r == MODE_STOPPED) begin
          mode_nxt = MODE_STARTUP;
        end else if (!ramp_done_r) begin
          load_drive   = 1'b1;
          step_cnt_nxt = sc_inc;
          if (in_lock) begin
            // rotor lock: hold step 0 at the lock duty
            lock_path = 1'b1;
            duty_nxt  = lock_cmp_r;
            phase_nxt = '0;
          end else begin
            duty_nxt   = ramp_duty;
            period_nxt = ramp_per;
            if (ramp_end) begin
              step_cnt_nxt  = '0;
              ramp_done_nxt = 1'b1;
              period_nxt    = PERIOD_AFTER_RAMP;
            end
            phase_nxt = phase_adv;
          end
        end else begin
          load_drive = 1'b1;
          mode_nxt   = MODE_RUNNING;
          phase_nxt  = phase_adv;
        end
      end else begin
        // reference command: start or stop, then duty while running
        if ((mode_r == MODE_STOPPED) && ref_hi) begin
          ramp_done_nxt = 1'b0;
        end else if ((mode_r != MODE_STOPPED) && !ref_hi) begin
          mode_nxt      = MODE_STOPPED;
          ramp_done_nxt = 1'b0;
          step_cnt_nxt  = '0;
        end
        if (mode_nxt == MODE_RUNNING) begin
          duty_nxt = s1_ref_r;
          acc_nxt  = 1'b1;
        end
      end
    end
  end

  // trigger sits just below the duty, floored at zero; lock uses the off level
  logic [CMP_W-1:0] trig_nxt;
  drive_t           drive_new;

  assign trig_nxt = lock_path ? off_level
                    : ((duty_nxt == '0) ? '0 : duty_nxt - 16'd1);

  bldc6_drive u_drive (
    .phase     (phase_nxt),
    .duty      (duty_nxt),
    .off_level (off_level),
    .trig      (trig_nxt),
    .drive     (drive_new)
  );

  assign drive_nxt = load_drive ? drive_new : drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOPPED;
      ramp_done_r <= 1'b0;
      step_cnt_r  <= '0;
      phase_r     <= '0;
      duty_r      <= '0;
      period_r    <= RST_START_PER;
      drive_r     <= '{u_hi: '0, u_lo: '0, v_hi: '0, v_lo: '0, w_hi: '0, w_lo: '0,
                       trig: '0, measure: SLICE_W_PH};
    end else begin
      mode_r      <= mode_nxt;
      ramp_done_r <= ramp_done_nxt;
      step_cnt_r  <= step_cnt_nxt;
      phase_r     <= phase_nxt;
      duty_r      <= duty_nxt;
      period_r    <= period_nxt;
      drive_r     <= drive_nxt;
    end
  end

  // result register: snapshot of the state after the word
  logic [PHASE_W-1:0] out_phase_r;
  drive_t             out_drive_r;
  logic [CMP_W-1:0]   out_period_r;
  logic [MODE_W-1:0]  out_mode_r;
  logic               out_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_phase_r  <= phase_nxt;
      out_drive_r  <= drive_nxt;
      out_period_r <= period_nxt;
      out_mode_r   <= mode_nxt;
      out_acc_r    <= acc_nxt;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.phase              = out_phase_r;
  assign out_ch.measure_phase      = out_drive_r.measure;
  assign out_ch.u_high_compare     = out_drive_r.u_hi;
  assign out_ch.u_low_compare      = out_drive_r.u_lo;
  assign out_ch.v_high_compare     = out_drive_r.v_hi;
  assign out_ch.v_low_compare      = out_drive_r.v_lo;
  assign out_ch.w_high_compare     = out_drive_r.w_hi;
  assign out_ch.w_low_compare      = out_drive_r.w_lo;
  assign out_ch.sample_trigger     = out_drive_r.trig;
  assign out_ch.commutation_period = out_period_r;
  assign out_ch.motor_mode         = out_mode_r;
  assign out_ch.accepted           = out_acc_r;

  // a stopped motor never carries a partial step count
  a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_STOPPED) |-> (step_cnt_r == '0))
    else $error("step count not cleared while stopped");

  // the step counter is idle once the ramp is finished
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_done_r |-> (step_cnt_r == '0))
    else $error("step count running after ramp end");

  // a low reference always leaves the motor stopped
  a_low_ref_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s1_kind_r && !ref_hi) |=> (mode_r == MODE_STOPPED))
    else $error("low reference did not stop the motor");

  // the commutation step stays in range
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= LAST_PHASE))
    else $error("commutation step out of range");

endmodule

@@ tb/bldc6_checker.sv @@
// result checker: predicts each result word of the six-step commutator and compares it
`timescale 1ns / 100ps
module bldc6_checker
  import bldc6_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bldc6_in_if                   in_ch,
  bldc6_out_if                  out_ch,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    running_seen
);

  localparam logic KIND_TICK = 1'b0;
  localparam int   MAX_REPORTS = 40;

  // per-step slice maps, step 0 in the low bits
  localparam logic [6*SLICE_W-1:0] HIGH_SIDE =
    {SLICE_W_PH, SLICE_W_PH, SLICE_V, SLICE_V, SLICE_U, SLICE_U};
  localparam logic [6*SLICE_W-1:0] LOW_ON =
    {SLICE_V, SLICE_U, SLICE_U, SLICE_W_PH, SLICE_W_PH, SLICE_V};
  localparam logic [6*SLICE_W-1:0] FLOATING =
    {SLICE_U, SLICE_V, SLICE_W_PH, SLICE_U, SLICE_V, SLICE_W_PH};

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [SLICE_W-1:0] measure;
    logic [CMP_W-1:0]   u_hi;
    logic [CMP_W-1:0]   u_lo;
    logic [CMP_W-1:0]   v_hi;
    logic [CMP_W-1:0]   v_lo;
    logic [CMP_W-1:0]   w_hi;
    logic [CMP_W-1:0]   w_lo;
    logic [CMP_W-1:0]   trig;
    logic [CMP_W-1:0]   period;
    logic [MODE_W-1:0]  mode;
    logic               accepted;
  } motor_word_t;

  // configuration copy
  logic [CMP_W-1:0] c_pwm, c_lock_cmp, c_start_per, c_per_step, c_lock_ticks, c_ramp_ticks;
  logic [Q8_W-1:0]  c_duty_start, c_duty_step;

  // motor state copy
  logic [MODE_W-1:0]  m_mode;
  logic               m_ramp_done;
  logic [STEP_W-1:0]  m_steps;
  logic [PHASE_W-1:0] m_phase;
  logic [CMP_W-1:0]   m_duty, m_period, m_trig;
  logic [CMP_W-1:0]   m_cmp [6];
  logic [SLICE_W-1:0] m_sense;

  motor_word_t motor_words_due [$];

  function automatic void set_bridge(input logic [PHASE_W-1:0] ph, input logic [CMP_W-1:0] trig);
    logic [CMP_W-1:0]   off;
    logic [SLICE_W-1:0] hs, ls;
    off = c_pwm + 1'b1;
    hs  = HIGH_SIDE[ph*SLICE_W +: SLICE_W];
    ls  = LOW_ON[ph*SLICE_W +: SLICE_W];
    for (int s = 0; s < 3; s++) begin
      m_cmp[2*s]   = (s == hs) ? m_duty : '0;
      m_cmp[2*s+1] = (s == ls) ? '0 : off;
    end
    m_trig  = trig;
    m_sense = FLOATING[ph*SLICE_W +: SLICE_W];
  endfunction

  function automatic void advance_commutation();
    logic [STEP_W-1:0]     past_lock;
    logic [DUTY_DEC_W-1:0] duty_step_w, duty_k, duty_drop, duty_left;
    logic [PER_DEC_W-1:0]  per_step_w, per_k, per_drop;
    if (m_mode == MODE_STOPPED) begin
      m_mode = MODE_STARTUP;
      return;
    end
    if (m_ramp_done) begin
      m_mode = MODE_RUNNING;
    end else begin
      m_steps = m_steps + 1'b1;
      if (m_steps <= c_lock_ticks) begin
        // rotor lock: held on step 0
        m_duty  = c_lock_cmp;
        m_phase = '0;
        set_bridge('0, c_pwm + 1'b1);
        return;
      end
      past_lock   = m_steps - c_lock_ticks;
      duty_step_w = DUTY_DEC_W'(c_duty_step);
      duty_k      = DUTY_DEC_W'(past_lock - 1'b1);
      duty_drop   = duty_step_w * duty_k;
      if (duty_drop >= c_duty_start) begin
        m_duty = '0;
      end else begin
        duty_left = c_duty_start - duty_drop;
        m_duty    = duty_left[8 +: CMP_W];
      end
      per_step_w = PER_DEC_W'(c_per_step);
      per_k      = PER_DEC_W'(past_lock);
      per_drop   = per_step_w * per_k;
      m_period   = (per_drop >= c_start_per) ? '0 : c_start_per - per_drop[CMP_W-1:0];
      if (past_lock >= c_ramp_ticks) begin
        m_steps     = '0;
        m_ramp_done = 1'b1;
        m_period    = PERIOD_AFTER_RAMP;
      end
    end
    m_phase = (m_phase >= LAST_PHASE) ? '0 : m_phase + 1'b1;
    set_bridge(m_phase, (m_duty == '0) ? '0 : m_duty - 1'b1);
  endfunction

  function automatic logic apply_reference(input logic [CMP_W-1:0] ref_value);
    if (m_mode == MODE_STOPPED && ref_value > REF_THRESHOLD) begin
      m_ramp_done = 1'b0;
    end else if (m_mode != MODE_STOPPED && ref_value <= REF_THRESHOLD) begin
      m_mode      = MODE_STOPPED;
      m_ramp_done = 1'b0;
      m_steps     = '0;
    end
    if (m_mode == MODE_RUNNING) begin
      m_duty = ref_value;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic motor_word_t state_word(input logic acc);
    motor_word_t w;
    w.phase    = m_phase;
    w.measure  = m_sense;
    w.u_hi     = m_cmp[0];
    w.u_lo     = m_cmp[1];
    w.v_hi     = m_cmp[2];
    w.v_lo     = m_cmp[3];
    w.w_hi     = m_cmp[4];
    w.w_lo     = m_cmp[5];
    w.trig     = m_trig;
    w.period   = m_period;
    w.mode     = m_mode;
    w.accepted = acc;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [CMP_W-1:0] want,
                             input logic [CMP_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: word %0d %s expected 0x%h actual 0x%h",
                 $time, checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    motor_word_t got, want;
    logic        acc;
    if (!rst_n) begin
      c_pwm        = RST_PWM_PERIOD;
      c_lock_cmp   = RST_LOCK_CMP;
      c_duty_start = RST_DUTY_START;
      c_duty_step  = RST_DUTY_STEP;
      c_start_per  = RST_START_PER;
      c_per_step   = RST_PER_STEP;
      c_lock_ticks = RST_LOCK_TICKS;
      c_ramp_ticks = RST_RAMP_TICKS;
      m_mode       = MODE_STOPPED;
      m_ramp_done  = 1'b0;
      m_steps      = '0;
      m_phase      = '0;
      m_duty       = '0;
      m_period     = RST_START_PER;
      m_trig       = '0;
      m_sense      = SLICE_W_PH;
      for (int i = 0; i < 6; i++) m_cmp[i] = '0;
      motor_words_due.delete();
      pending = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.phase    = out_ch.phase;
        got.measure  = out_ch.measure_phase;
        got.u_hi     = out_ch.u_high_compare;
        got.u_lo     = out_ch.u_low_compare;
        got.v_hi     = out_ch.v_high_compare;
        got.v_lo     = out_ch.v_low_compare;
        got.w_hi     = out_ch.w_high_compare;
        got.w_lo     = out_ch.w_low_compare;
        got.trig     = out_ch.sample_trigger;
        got.period   = out_ch.commutation_period;
        got.mode     = out_ch.motor_mode;
        got.accepted = out_ch.accepted;
        if (got.mode == MODE_RUNNING) running_seen++;
        if (motor_words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: result word expected none actual 0x%h", $time, got);
        end else begin
          want = motor_words_due.pop_front();
          check_field("phase", want.phase, got.phase);
          check_field("measure_phase", want.measure, got.measure);
          check_field("u_high_compare", want.u_hi, got.u_hi);
          check_field("u_low_compare", want.u_lo, got.u_lo);
          check_field("v_high_compare", want.v_hi, got.v_hi);
          check_field("v_low_compare", want.v_lo, got.v_lo);
          check_field("w_high_compare", want.w_hi, got.w_hi);
          check_field("w_low_compare", want.w_lo, got.w_lo);
          check_field("sample_trigger", want.trig, got.trig);
          check_field("commutation_period", want.period, got.period);
          check_field("motor_mode", want.mode, got.mode);
          check_field("accepted", want.accepted, got.accepted);
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        acc = 1'b0;
        if (in_ch.kind == KIND_TICK) advance_commutation();
        else acc = apply_reference(in_ch.reference);
        motor_words_due.push_back(state_word(acc));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PWM_PERIOD: c_pwm        = cfg_wdata[CMP_W-1:0];
          REG_LOCK_CMP:   c_lock_cmp   = cfg_wdata[CMP_W-1:0];
          REG_DUTY_START: c_duty_start = cfg_wdata[Q8_W-1:0];
          REG_DUTY_STEP:  c_duty_step  = cfg_wdata[Q8_W-1:0];
          REG_START_PER:  c_start_per  = cfg_wdata[CMP_W-1:0];
          REG_PER_STEP:   c_per_step   = cfg_wdata[CMP_W-1:0];
          REG_LOCK_TICKS: c_lock_ticks = cfg_wdata[CMP_W-1:0];
          REG_RAMP_TICKS: c_ramp_ticks = cfg_wdata[CMP_W-1:0];
          default: ;
        endcase
      end
      pending = motor_words_due.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// top of the commutator testbench: clock, reset, stimulus, idling and the verdict
`timescale 1ns / 100ps
module tb;
  import bldc6_pkg::*;

  // input word kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  // longest run of cycles with no word moving on either channel; the slowest
  // healthy gap is a receiver stall at 64 % idling plus a drain and a register
  // load, so this leaves a wide margin
  localparam int QUIET_LIMIT = 2000;
  // pipeline holds an input register and a result register; spare cycles catch stray result words
  localparam int DRAIN_TAIL  = 6;
  localparam int PHASE_WORDS = 65;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bldc6_in_if  in_ch ();
  bldc6_out_if out_ch ();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_ticks       = 0;
  int n_commands    = 0;
  int n_settings    = 0;

  // checker results
  int n_fail, n_pending, n_checked, n_running;

  bldc_six_step_openloop_start u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  bldc6_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (n_fail),
    .pending      (n_pending),
    .checked      (n_checked),
    .running_seen (n_running)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // result side back-pressure, redrawn every cycle on the falling edge
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input word; called on a falling edge and returns on a falling edge,
  // so valid stays high between back-to-back words without being re-driven
  task automatic send_word(input logic kind, input logic [CMP_W-1:0] ref_value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.reference <= ref_value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (kind == KIND_TICK) n_ticks++;
    else n_commands++;
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, CMP_W'($urandom));
  endtask

  task automatic send_command(input logic [CMP_W-1:0] ref_value);
    send_word(KIND_COMMAND, ref_value);
  endtask

  // mostly commutation ticks so the motor gets through lock and ramp into
  // running; drive references above the threshold, now and then a stop
  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) send_tick();
    else if (pick < 92) send_command(CMP_W'($urandom_range(65535, 126)));
    else if (pick < 96) send_command(CMP_W'($urandom_range(125)));
    else send_command(CMP_W'($urandom));
  endtask

  // wait until every predicted word has come back, then a short tail
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // full register set; only ever called with the block idle
  task automatic load_settings(input logic [CMP_W-1:0] pwm, lock_cmp,
                               input logic [Q8_W-1:0] duty_start, duty_step,
                               input logic [CMP_W-1:0] start_per, per_step, lock_ticks,
                               ramp_ticks);
    write_reg(REG_PWM_PERIOD, CFG_DATA_W'(pwm));
    write_reg(REG_LOCK_CMP, CFG_DATA_W'(lock_cmp));
    write_reg(REG_DUTY_START, duty_start);
    write_reg(REG_DUTY_STEP, duty_step);
    write_reg(REG_START_PER, CFG_DATA_W'(start_per));
    write_reg(REG_PER_STEP, CFG_DATA_W'(per_step));
    write_reg(REG_LOCK_TICKS, CFG_DATA_W'(lock_ticks));
    write_reg(REG_RAMP_TICKS, CFG_DATA_W'(ramp_ticks));
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int n_words;
    // every block input known from time zero
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PWM_PERIOD;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TICK;
    in_ch.reference = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 22;
    recv_idle_pct = 64;

    // default registers: stop while stopped, entry into startup, rotor lock,
    // a start request ignored in startup, stop at the threshold, restart
    send_command(16'd0);
    send_tick();
    send_tick();
    send_command(16'd200);
    send_tick();
    send_command(REF_THRESHOLD);
    send_command(16'hFFFF);
    send_tick();
    send_tick();

    // off level wraps to zero, no lock, a ramp of zero ticks ending at once,
    // saturated period, then running with both reference extremes and a
    // full turn through all six steps
    settle();
    load_settings(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd0);
    send_command(16'd0);
    send_tick();
    send_tick();
    send_tick();
    send_command(16'hFFFF);
    send_tick();
    send_command(REF_THRESHOLD + 1'b1);
    send_tick();
    send_tick();
    send_tick();
    send_tick();

    // zero lock duty and zero ramp duty: the ramp trigger floors at zero;
    // then a stop out of running and a stop while already stopped
    settle();
    load_settings(16'd1279, 16'd0, 24'd0, 24'd910, 16'd20618, 16'd243, 16'd1, 16'd2);
    send_command(16'd0);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_command(REF_THRESHOLD);
    send_command(16'd0);

    // random part: one register setting per phase, idling stages in turn
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      n_words = PHASE_WORDS;
      case (ph)
        0: begin
          // reset-like values but a short start-up
          load_settings(16'd1279, 16'd511, 24'd130970, 24'd910, 16'd20618, 16'd243,
                        16'd2, 16'd5);
        end
        1: begin
          // anything goes in the arithmetic registers
          load_settings(CMP_W'($urandom_range(65534, 1)), CMP_W'($urandom),
                        Q8_W'($urandom), Q8_W'($urandom),
                        CMP_W'($urandom_range(65535, 1)), CMP_W'($urandom),
                        CMP_W'($urandom_range(3)), CMP_W'($urandom_range(6, 1)));
        end
        2: begin
          // receiver now idles lightly, sender heavily
          send_idle_pct = 64;
          recv_idle_pct = 22;
          load_settings(CMP_W'($urandom_range(65534, 1)), CMP_W'($urandom),
                        Q8_W'($urandom), Q8_W'($urandom_range(4095)),
                        CMP_W'($urandom_range(65535, 1)), CMP_W'($urandom_range(4095)),
                        CMP_W'($urandom_range(3)), CMP_W'($urandom_range(8, 1)));
        end
        3: begin
          // low extremes
          load_settings(16'd1, 16'd0, 24'd0, 24'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        end
        4: begin
          // no idling from here on; high extremes
          send_idle_pct = 0;
          recv_idle_pct = 0;
          load_settings(16'd65534, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                        16'd1, 16'd2);
        end
        5: begin
          load_settings(CMP_W'($urandom_range(65534, 1)), CMP_W'($urandom),
                        Q8_W'($urandom), Q8_W'($urandom_range(4095)),
                        CMP_W'($urandom_range(65535, 1)), CMP_W'($urandom_range(4095)),
                        CMP_W'($urandom_range(3)), CMP_W'($urandom_range(8, 1)));
        end
        default: begin
          // longest lock and ramp: a motor that enters the lock here never gets out of it
          n_words = 30;
          load_settings(16'd1279, 16'd511, 24'd130970, 24'd910, 16'd20618, 16'd243,
                        16'hFFFF, 16'hFFFF);
        end
      endcase
      repeat (n_words) send_random();
    end

    settle();

    $display("tb: %0d words sent (%0d ticks, %0d commands) under %0d register settings",
             n_ticks + n_commands, n_ticks, n_commands, n_settings);
    $display("tb: %0d result words checked, %0d of them with the motor running",
             n_checked, n_running);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
